[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Property shorthands for the checker module of the project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while rst is high.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while rst is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hw/rtl/mafrm_pkg.sv]
// ----------------------------------------------------------------------------
// mafrm_pkg
// Widths, constants and payload types of the moving-average frame rate meter.
// ----------------------------------------------------------------------------
package mafrm_pkg;

   // Number of intervals averaged over.
   localparam int WINDOW    = 16;

   localparam int STAMP_W   = 32;
   localparam int FPS_W     = 16;
   localparam int TOTAL_W   = 32;

   // Sum of WINDOW intervals of STAMP_W bits each.
   localparam int SUM_W     = STAMP_W + $clog2(WINDOW);
   localparam int FILL_W    = $clog2(WINDOW + 1);
   localparam int SLOT_W    = $clog2(WINDOW);

   // Milliseconds per second: scales the millisecond intervals to frames per second.
   localparam int FPS_SCALE = 1000;
   localparam int NUM_W     = $clog2(FPS_SCALE * WINDOW + 1);
   localparam int STEP_W    = $clog2(NUM_W);

   // Width at which the divider compares its partial remainder with the sum.
   localparam int CMP_W     = (SUM_W > NUM_W + 1) ? SUM_W : NUM_W + 1;

   localparam logic [FPS_W-1:0] FPS_MAX = '1;

   typedef logic [STAMP_W-1:0] stamp_type;
   typedef logic [FPS_W-1:0]   fps_type;
   typedef logic [TOTAL_W-1:0] total_type;
   typedef logic [SUM_W-1:0]   sum_type;

endpackage

[hw/rtl/mafrm_req_if.sv]
// ----------------------------------------------------------------------------
// mafrm_req_if
// Request channel of the frame rate meter: one frame timestamp per request.
// ----------------------------------------------------------------------------
interface mafrm_req_if;
   import mafrm_pkg::*;

   logic      valid;
   logic      ready;
   stamp_type timestamp_ms;

   modport source (output valid, output timestamp_ms, input ready);
   modport sink   (input valid, input timestamp_ms, output ready);
endinterface

[hw/rtl/mafrm_rsp_if.sv]
// ----------------------------------------------------------------------------
// mafrm_rsp_if
// Response channel of the frame rate meter: rate, saturation flag and count.
// ----------------------------------------------------------------------------
interface mafrm_rsp_if;
   import mafrm_pkg::*;

   logic      valid;
   logic      ready;
   fps_type   frames_per_second;
   logic      fps_saturated;
   total_type total_frames;

   modport source (output valid, output frames_per_second, output fps_saturated,
                   output total_frames, input ready);
   modport sink   (input valid, input frames_per_second, input fps_saturated,
                   input total_frames, output ready);
endinterface

[hw/rtl/moving_average_frame_rate_meter_core.sv]
// ----------------------------------------------------------------------------
// moving_average_frame_rate_meter_core
// Moving-average frames-per-second meter over a ring of frame intervals.
// ----------------------------------------------------------------------------
// Each request carries the millisecond timestamp of a finished frame and
// produces one response: floor(1000 * filled / sum of intervals), saturating
// at 65535 with a flag when the sum is zero or the quotient is too large,
// plus the total frame count. The first frame after reset starts the meter
// with a zero interval. One request is handled at a time: ready drops when a
// request is accepted and rises again once the result has been handed to the
// output register. The meter removes the outgoing interval, adds the new one,
// then runs the restoring divider, which produces one quotient bit per cycle
// over the NUM_W bits of the numerator, and last hands over the result. A
// finished response waits in the output register while the next request is
// accepted; if it has still not been taken when the next result is ready,
// the meter stays busy until it is. No clearing pass is needed after reset.
module moving_average_frame_rate_meter_core (
   input  logic        clock,
   input  logic        reset,
   mafrm_req_if.sink   req_chan,
   mafrm_rsp_if.source rsp_chan
);
   import mafrm_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SUB,
      ST_ADD,
      ST_DIV,
      ST_DONE
   } state_type;

   state_type               state_ff, state_in;
   logic                    started_ff, started_in;
   stamp_type               stamp_ff, stamp_in;
   stamp_type               prev_ff, prev_in;
   stamp_type               gap_ff, gap_in;
   sum_type                 sum_ff, sum_in;
   logic [FILL_W-1:0]       fill_ff, fill_in;
   logic [SLOT_W-1:0]       slot_ff, slot_in;
   total_type               total_ff, total_in;
   logic [NUM_W-1:0]        rem_ff, rem_in;
   logic [NUM_W-1:0]        quot_ff, quot_in;
   logic [STEP_W-1:0]       step_ff, step_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   fps_type                 rsp_fps_ff, rsp_fps_in;
   logic                    rsp_sat_ff, rsp_sat_in;
   total_type               rsp_total_ff, rsp_total_in;

   // Interval ring and its registered read port.
   stamp_type               ring_mem [WINDOW];
   stamp_type               ring_rd_ff;
   logic                    ring_we;

   logic                    window_full;
   stamp_type               old_gap;
   logic [CMP_W-1:0]        rem_shift;
   logic [CMP_W-1:0]        sum_cmp;
   logic                    rem_ge;
   logic                    sum_zero;
   logic                    quot_over;

   assign req_chan.ready          = (state_ff == ST_IDLE);
   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.frames_per_second = rsp_fps_ff;
   assign rsp_chan.fps_saturated  = rsp_sat_ff;
   assign rsp_chan.total_frames   = rsp_total_ff;

   // Slots fill in order from zero, so until the ring is full the slot about
   // to be written has never held an interval and counts as zero.
   assign window_full = (fill_ff == FILL_W'(WINDOW));
   assign old_gap     = window_full ? ring_rd_ff : '0;

   // One restoring division step: shift in the next numerator bit and
   // subtract the sum when it fits.
   assign rem_shift = CMP_W'({rem_ff, quot_ff[NUM_W-1]});
   assign sum_cmp   = CMP_W'(sum_ff);
   assign rem_ge    = (rem_shift >= sum_cmp);

   assign sum_zero  = (sum_ff == '0);
   assign quot_over = (32'(quot_ff) > 32'(FPS_MAX));

   // Ring storage: written once per frame, read at the current slot.
   always_ff @(posedge clock) begin
      if (ring_we) begin
         ring_mem[slot_ff] <= gap_in;
      end
      ring_rd_ff <= ring_mem[slot_ff];
   end

   // Sequencer next-state logic.
   always_comb begin
      state_in     = state_ff;
      started_in   = started_ff;
      stamp_in     = stamp_ff;
      prev_in      = prev_ff;
      gap_in       = gap_ff;
      sum_in       = sum_ff;
      fill_in      = fill_ff;
      slot_in      = slot_ff;
      total_in     = total_ff;
      rem_in       = rem_ff;
      quot_in      = quot_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_fps_in   = rsp_fps_ff;
      rsp_sat_in   = rsp_sat_ff;
      rsp_total_in = rsp_total_ff;
      ring_we      = 1'b0;

      // A taken response frees the output register.
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               stamp_in = req_chan.timestamp_ms;
               state_in = ST_SUB;
            end
         end

         // Work out the interval, store it and remove the outgoing one.
         ST_SUB: begin
            gap_in     = started_ff ? (stamp_ff - prev_ff) : '0;
            prev_in    = stamp_ff;
            started_in = 1'b1;
            ring_we    = 1'b1;
            sum_in     = sum_ff - SUM_W'(old_gap);
            state_in   = ST_ADD;
         end

         // Add the new interval, advance the counters, load the divider.
         ST_ADD: begin
            sum_in   = sum_ff + SUM_W'(gap_ff);
            fill_in  = window_full ? fill_ff : fill_ff + 1'b1;
            slot_in  = (slot_ff == SLOT_W'(WINDOW - 1)) ? '0 : slot_ff + 1'b1;
            total_in = total_ff + 1'b1;
            quot_in  = NUM_W'(FPS_SCALE * int'(fill_in));
            rem_in   = '0;
            step_in  = STEP_W'(NUM_W - 1);
            state_in = ST_DIV;
         end

         ST_DIV: begin
            if (rem_ge) begin
               rem_in = NUM_W'(rem_shift - sum_cmp);
            end else begin
               rem_in = NUM_W'(rem_shift);
            end
            quot_in = {quot_ff[NUM_W-2:0], rem_ge};
            if (step_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               step_in = step_ff - 1'b1;
            end
         end

         // Hand the result to the output register once it is free.
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_sat_in   = sum_zero || quot_over;
               rsp_fps_in   = (sum_zero || quot_over) ? FPS_MAX : FPS_W'(quot_ff);
               rsp_total_in = total_ff;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         started_ff   <= 1'b0;
         prev_ff      <= '0;
         sum_ff       <= '0;
         fill_ff      <= '0;
         slot_ff      <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         started_ff   <= started_in;
         prev_ff      <= prev_in;
         sum_ff       <= sum_in;
         fill_ff      <= fill_in;
         slot_ff      <= slot_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      stamp_ff     <= stamp_in;
      gap_ff       <= gap_in;
      rem_ff       <= rem_in;
      quot_ff      <= quot_in;
      step_ff      <= step_in;
      rsp_fps_ff   <= rsp_fps_in;
      rsp_sat_ff   <= rsp_sat_in;
      rsp_total_ff <= rsp_total_in;
   end

endmodule

[hw/rtl/mafrm_checker.sv]
// ----------------------------------------------------------------------------
// mafrm_checker
// Port-level checks of the frame rate meter, bound to its top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mafrm_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input mafrm_pkg::fps_type   rsp_fps,
   input logic                 rsp_sat,
   input mafrm_pkg::total_type rsp_total
);
   import mafrm_pkg::*;

   // A saturated response always carries the top rate.
   `ASSERT_IMPL(a_sat_means_max, clock, reset, rsp_valid && rsp_sat, rsp_fps == FPS_MAX, "saturated response without top rate")

   // A request occupies the meter, so it cannot take another straight away.
   `ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && req_ready, !req_ready, "meter ready in the cycle after a request")

   // Reset leaves no response pending.
   `ASSERT_NEXT(a_reset_clears_rsp, clock, 1'b0, reset, !rsp_valid, "response pending after reset")

   // A stalled response holds its contents.
   `ASSERT_NEXT(a_rsp_holds, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_fps) && $stable(rsp_sat) && $stable(rsp_total), "stalled response changed")

endmodule

bind moving_average_frame_rate_meter_core mafrm_checker u_mafrm_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_fps   (rsp_chan.frames_per_second),
   .rsp_sat   (rsp_chan.fps_saturated),
   .rsp_total (rsp_chan.total_frames)
);

[bench/tb_moving_average_frame_rate_meter_core.sv]
// ----------------------------------------------------------------------------
// tb_moving_average_frame_rate_meter_core
// Self-checking bench for the moving-average frame rate meter.
// ----------------------------------------------------------------------------
// Frame timestamps are sent as requests with random idle bursts on both
// channels. A short table of opening frames covers meter start, a zero
// interval sum, wrapping and backward timestamps and the fill of the ring.
// It is followed by random bursts of steady, frozen, random and jumping
// frame timings. Every response is compared field by field with its table
// reading where one is given, else with a behavioural meter copy in the bench.
module tb_moving_average_frame_rate_meter_core;
   timeunit 1ns;
   timeprecision 1ps;

   import mafrm_pkg::*;

   localparam int OPENING_FRAMES = 25;
   localparam int RANDOM_FRAMES  = 1025;
   localparam int TAIL_FRAMES    = 150;
   localparam int DRAIN_CYCLES   = 2 * (NUM_W + 4);
   localparam int STALL_LIMIT    = 2000;

   typedef struct packed {
      fps_type   fps;
      logic      saturated;
      total_type total;
   } rate_reading_t;

   typedef struct {
      stamp_type     stamp;
      bit            typed;
      rate_reading_t reading;
   } frame_row_t;

   typedef enum {PACE_STEADY, PACE_FROZEN, PACE_RANDOM, PACE_JUMP} pace_mode_t;

   logic clock;
   logic reset;

   mafrm_req_if req_chan ();
   mafrm_rsp_if rsp_chan ();

   moving_average_frame_rate_meter_core DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Bench copy of the meter state.
   stamp_type   gap_ring [WINDOW] = '{default: '0};
   sum_type     gap_sum       = '0;
   stamp_type   last_stamp    = '0;
   bit          meter_running = 1'b0;
   total_type   frame_count   = '0;
   int unsigned ring_fill     = 0;
   int unsigned next_slot     = 0;

   rate_reading_t expected_readings [$];
   rate_reading_t row_reading;
   bit            row_typed       = 1'b0;
   bit            quiet_tail      = 1'b0;
   int unsigned   frames_accepted = 0;
   int unsigned   readings_seen   = 0;
   int unsigned   error_count     = 0;
   int unsigned   idle_cycles     = 0;

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Advance the meter copy by one frame and give the reading it produces.
   task automatic advance_meter(input stamp_type stamp, output rate_reading_t reading);
      stamp_type       gap;
      longint unsigned rate;
      begin
         // The first frame clears the ring and records a zero interval.
         if (!meter_running) begin
            foreach (gap_ring[i]) gap_ring[i] = '0;
            gap_sum       = '0;
            last_stamp    = stamp;
            meter_running = 1'b1;
         end
         gap                 = stamp - last_stamp;
         gap_sum             = gap_sum - sum_type'(gap_ring[next_slot]) + sum_type'(gap);
         gap_ring[next_slot] = gap;
         last_stamp          = stamp;
         next_slot           = (next_slot + 1 >= WINDOW) ? 0 : next_slot + 1;
         if (ring_fill < WINDOW) ring_fill++;
         frame_count   = frame_count + 1'b1;
         reading.total = frame_count;

         // A zero sum or an oversized quotient saturates the rate.
         if (gap_sum == '0) begin
            reading.fps       = FPS_MAX;
            reading.saturated = 1'b1;
         end else begin
            rate = (longint'(FPS_SCALE) * ring_fill) / gap_sum;
            if (rate > FPS_MAX) begin
               reading.fps       = FPS_MAX;
               reading.saturated = 1'b1;
            end else begin
               reading.fps       = fps_type'(rate);
               reading.saturated = 1'b0;
            end
         end
      end
   endtask

   task automatic report_mismatch(input string field, input longint got, input longint want);
      begin
         $display("MISMATCH response %0d: %s is %0d, expected %0d",
                  readings_seen, field, got, want);
         error_count++;
      end
   endtask

   // Check responses and record the reading due for each accepted request.
   always @(posedge clock) begin
      rate_reading_t want;
      rate_reading_t predicted;
      if (!reset) begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_readings.size() == 0) begin
               $display("MISMATCH response %0d arrived with no request outstanding",
                        readings_seen);
               error_count++;
            end else begin
               want = expected_readings.pop_front();
               if (rsp_chan.frames_per_second !== want.fps)
                  report_mismatch("frames_per_second", rsp_chan.frames_per_second, want.fps);
               if (rsp_chan.fps_saturated !== want.saturated)
                  report_mismatch("fps_saturated", rsp_chan.fps_saturated, want.saturated);
               if (rsp_chan.total_frames !== want.total)
                  report_mismatch("total_frames", rsp_chan.total_frames, want.total);
            end
            readings_seen++;
         end
         if (req_chan.valid && req_chan.ready) begin
            advance_meter(req_chan.timestamp_ms, predicted);
            expected_readings.push_back(row_typed ? row_reading : predicted);
            frames_accepted++;
         end
      end
   end

   // Watchdog on cycles in which neither channel moves anything.
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("FAIL moving_average_frame_rate_meter_core");
         $finish;
      end
   end

   // Response side back-pressure: stall bursts between stretches of ready.
   initial begin
      int unsigned hold;
      hold           = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (quiet_tail) begin
            rsp_chan.ready = 1'b1;
         end else if (hold > 0) begin
            hold--;
         end else if ($urandom_range(0, 3) == 0) begin
            rsp_chan.ready = 1'b0;
            hold           = $urandom_range(1, 10) - 1;
         end else begin
            rsp_chan.ready = 1'b1;
            hold           = $urandom_range(0, 20);
         end
      end
   end

   // Present one frame, possibly after an idle burst, and wait for acceptance.
   task automatic send_frame(input stamp_type stamp, input bit typed,
                             input rate_reading_t reading);
      int unsigned seen;
      int unsigned pause;
      begin
         if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            req_chan.valid = 1'b0;
            pause          = $urandom_range(1, 10);
            repeat (pause) @(negedge clock);
         end
         seen                  = frames_accepted;
         row_typed             = typed;
         row_reading           = reading;
         req_chan.valid        = 1'b1;
         req_chan.timestamp_ms = stamp;
         while (frames_accepted == seen) @(negedge clock);
      end
   endtask

   function automatic pace_mode_t pick_pace();
      int unsigned roll;
      begin
         roll = $urandom_range(0, 9);
         if (roll <= 5)      return PACE_STEADY;
         else if (roll <= 7) return PACE_FROZEN;
         else if (roll == 8) return PACE_RANDOM;
         else                return PACE_JUMP;
      end
   endfunction

   // Stimulus: opening table, then random frame timings.
   initial begin
      frame_row_t  opening_rows [OPENING_FRAMES];
      stamp_type   stamp;
      pace_mode_t  pace_mode;
      int unsigned pace;
      int unsigned burst_left;
      int unsigned sent;

      req_chan.valid        = 1'b0;
      req_chan.timestamp_ms = '0;
      reset                 = 1'b1;

      // Meter start on a zero stamp, a zero interval sum, a one-millisecond
      // interval, the largest stamp, a forward wrap and a backward step.
      opening_rows[0] = '{32'h0000_0000, 1'b1, '{FPS_MAX, 1'b1, 32'd1}};
      opening_rows[1] = '{32'h0000_0000, 1'b1, '{FPS_MAX, 1'b1, 32'd2}};
      opening_rows[2] = '{32'h0000_0001, 1'b1, '{16'd3000, 1'b0, 32'd3}};
      opening_rows[3] = '{32'hFFFF_FFFF, 1'b1, '{16'd0, 1'b0, 32'd4}};
      opening_rows[4] = '{32'h0000_0000, 1'b0, '0};
      opening_rows[5] = '{32'h8000_0000, 1'b0, '0};
      opening_rows[6] = '{32'h7FFF_FFFF, 1'b0, '0};
      // A steady 16 ms pace that flushes the large intervals out of the ring.
      for (int i = 7; i < OPENING_FRAMES; i++)
         opening_rows[i] = '{32'h7FFF_FFFF + 32'(16 * (i - 6)), 1'b0, '0};

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (opening_rows[i])
         send_frame(opening_rows[i].stamp, opening_rows[i].typed, opening_rows[i].reading);

      stamp      = opening_rows[OPENING_FRAMES-1].stamp;
      burst_left = 0;
      pace       = 16;
      pace_mode  = PACE_STEADY;
      for (sent = 0; sent < RANDOM_FRAMES; sent++) begin
         if (burst_left == 0) begin
            pace_mode  = pick_pace();
            pace       = $urandom_range(1, 60);
            // Frozen bursts must outlast the ring to bring the sum to zero.
            burst_left = (pace_mode == PACE_FROZEN) ? $urandom_range(16, 30)
                                                    : $urandom_range(5, 40);
         end
         case (pace_mode)
            PACE_STEADY: stamp = stamp + pace + $urandom_range(0, 3);
            PACE_FROZEN: stamp = stamp + (($urandom_range(0, 9) == 0) ? 1 : 0);
            PACE_RANDOM: stamp = $urandom;
            PACE_JUMP:   stamp = stamp + $urandom;
         endcase
         quiet_tail = (RANDOM_FRAMES - sent <= TAIL_FRAMES);
         send_frame(stamp, 1'b0, '0);
         burst_left--;
      end
      req_chan.valid = 1'b0;

      // Drain the outstanding responses, then watch for strays.
      while (expected_readings.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (error_count == 0)
         $display("PASS moving_average_frame_rate_meter_core");
      else
         $display("FAIL moving_average_frame_rate_meter_core");
      $finish;
   end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/mafrm_pkg.sv
hw/rtl/mafrm_req_if.sv
hw/rtl/mafrm_rsp_if.sv
hw/rtl/moving_average_frame_rate_meter_core.sv
hw/rtl/mafrm_checker.sv
bench/tb_moving_average_frame_rate_meter_core.sv
